### rtl/nss_pkg.sv
// Shared constants, types and state codes for the nearest segment search.
package nss_pkg;

  localparam int MaxSegments = 1024;
  localparam int CntW = $clog2(MaxSegments + 2);
  localparam int IdxW = 10;
  localparam int DistW = 32;
  localparam int CoordW = 32;
  localparam int DiffW = 33;
  localparam int SqW = 68;
  localparam int AccW = 72;
  localparam int TW = 25;
  localparam int RootW = 38;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLASS,
    ST_DIV,
    ST_SCALE,
    ST_SQ,
    ST_ROOT,
    ST_UPDATE
  } nss_state_t;

endpackage

### rtl/nss_serial_mul.sv
// Shift-and-add multiplier: one multiplier bit per cycle, unsigned magnitudes.
module nss_serial_mul import nss_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DiffW-1:0] mcand,
  input  logic [DiffW-1:0] mplier,
  output logic            done,
  output logic [SqW-1:0]  prod
);

  logic [SqW-1:0]   acc;
  logic [SqW-1:0]   sh;
  logic [DiffW-1:0] mq;
  logic [5:0]       cnt;
  logic             run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        acc <= '0;
        sh  <= SqW'(mcand);
        mq  <= mplier;
        cnt <= 6'(DiffW);
      end else if (run) begin
        if (mq[0]) acc <= acc + sh;
        sh  <= sh << 1;
        mq  <= mq >> 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

### rtl/nss_serial_root.sv
// Restoring square root: one result bit per cycle.
module nss_serial_root import nss_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [AccW-1:0] radicand,
  output logic           done,
  output logic [DistW-1:0] root
);

  logic [AccW-1:0]  rem;
  logic [AccW-1:0]  src;
  logic [RootW-1:0] res;
  logic [5:0]       cnt;
  logic             run;
  logic [AccW+1:0]  trial;
  logic [AccW+1:0]  cur;

  always_comb begin
    cur   = {rem, src[AccW-1 -: 2]};
    trial = cur - {(AccW+2-RootW-2)'(0), res, 2'b01};
  end

  // The radicand is consumed two bits per cycle, so AccW/2 steps cover it.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        rem <= '0;
        src <= radicand;
        res <= '0;
        cnt <= 6'(AccW / 2);
      end else if (run) begin
        src <= src << 2;
        if (!trial[AccW+1]) begin
          rem <= trial[AccW-1:0];
          res <= {res[RootW-2:0], 1'b1};
        end else begin
          rem <= cur[AccW-1:0];
          res <= {res[RootW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = (res[RootW-1:DistW] != '0) ? '1 : res[DistW-1:0];

endmodule

### rtl/nearest_segment_search.sv
// Top level of the nearest segment search.
// One item carries a query point, the two ends of a segment and a last mark.
// The block finds the point-to-segment distance, keeps the nearest segment of
// the current search, and on an item marked last delivers one result item with
// the winner's position, distance, projection side and an overflow flag.
// Both channels use valid and ready. The block takes one item at a time: it
// accepts an item only when idle and works on it until it returns to idle.
// The work is done by a shared bit-serial multiplier, a restoring divider for
// the projection and a bit-serial square root. Six products form the squared
// length and the dot product and three more square the distance components;
// an interior projection adds the divider and three scaling products.
// A finished result waits in an output register; the block still accepts and
// works on the next item while it waits, and stalls only if a new result is
// ready while the old one is still held.
// Reset clears the running best (distance set to its maximum), the counter and the output valid flag.
// Coordinates are signed Q16.16; the distance is unsigned Q16.16 and saturates.
module nearest_segment_search import nss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] query_x,
  input  logic signed [CoordW-1:0] query_y,
  input  logic signed [CoordW-1:0] query_z,
  input  logic signed [CoordW-1:0] end_a_x,
  input  logic signed [CoordW-1:0] end_a_y,
  input  logic signed [CoordW-1:0] end_a_z,
  input  logic signed [CoordW-1:0] end_b_x,
  input  logic signed [CoordW-1:0] end_b_y,
  input  logic signed [CoordW-1:0] end_b_z,
  input  logic                     last_segment,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IdxW-1:0]          best_index,
  output logic [DistW-1:0]         best_distance,
  output logic                     nearer_first_end,
  output logic                     count_overflow
);

  nss_state_t state, state_next;

  // Differences held as signed 33-bit values.
  logic signed [DiffW-1:0] w [3];
  logic signed [DiffW-1:0] d [3];
  logic signed [DiffW-1:0] e [3];
  logic signed [DiffW-1:0] v [3];
  logic                    last;

  // Product sequencing: step selects the operands for the shared multiplier.
  logic [3:0]      step;
  logic signed [AccW-1:0] len2;
  logic signed [AccW-1:0] dot;
  logic [AccW-1:0] sumsq;
  logic [1:0]      sel;      // 0: w, 1: e, 2: v
  logic            near;

  logic [DiffW-1:0] m_a, m_b;
  logic             m_neg;
  logic             m_start, m_start_next, m_done;
  logic [SqW-1:0]   m_prod;
  logic signed [AccW-1:0] m_signed;

  logic [AccW-1:0]  rem;
  logic [TW-1:0]    tq;
  logic [4:0]       dcnt;
  logic [AccW:0]    dtrial;

  logic             r_start, r_start_next, r_done;
  logic [DistW-1:0] r_root;

  logic [DistW-1:0] run_dist;
  logic [IdxW-1:0]  run_idx;
  logic             run_near;
  logic [CntW-1:0]  cnt;
  logic             take;     // this item becomes the running best
  logic             emit;     // the result item is written this cycle

  function automatic logic [DiffW-1:0] mag(input logic signed [DiffW-1:0] x);
    return x[DiffW-1] ? DiffW'(-x) : x;
  endfunction

  assign in_ready = (state == ST_IDLE);

  // Operand select for the shared multiplier.
  always_comb begin
    m_a   = '0;
    m_b   = '0;
    m_neg = 1'b0;
    unique case (state)
      ST_MUL: begin
        if (step < 4'd3) begin
          m_a = mag(d[step[1:0]]); m_b = mag(d[step[1:0]]);
        end else begin
          m_a = mag(w[2'(step - 4'd3)]); m_b = mag(d[2'(step - 4'd3)]);
          m_neg = w[2'(step - 4'd3)][DiffW-1] ^ d[2'(step - 4'd3)][DiffW-1];
        end
      end
      ST_SCALE: begin
        m_a = DiffW'(tq); m_b = mag(d[step[1:0]]);
      end
      ST_SQ: begin
        unique case (sel)
          2'd0:    begin m_a = mag(w[step[1:0]]); m_b = mag(w[step[1:0]]); end
          2'd1:    begin m_a = mag(e[step[1:0]]); m_b = mag(e[step[1:0]]); end
          default: begin m_a = mag(v[step[1:0]]); m_b = mag(v[step[1:0]]); end
        endcase
      end
      default: ;
    endcase
  end

  assign m_signed = m_neg ? -AccW'(m_prod) : AccW'(m_prod);
  assign dtrial   = {rem, 1'b0} - {1'b0, len2};

  nss_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(m_start), .mcand(m_a), .mplier(m_b),
    .done(m_done), .prod(m_prod)
  );

  nss_serial_root u_root (
    .clk(clk), .rst(rst), .start(r_start), .radicand(sumsq),
    .done(r_done), .root(r_root)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MUL;
      ST_MUL:    if (m_done && step == 4'd5) state_next = ST_CLASS;
      ST_CLASS:  state_next = (len2 != '0 && !dot[AccW-1] && !(dot > len2)) ? ST_DIV : ST_SQ;
      ST_DIV:    if (dcnt == 5'd0) state_next = ST_SCALE;
      ST_SCALE:  if (m_done && step == 4'd2) state_next = ST_SQ;
      ST_SQ:     if (m_done && step == 4'd2) state_next = ST_ROOT;
      ST_ROOT:   if (r_done) state_next = ST_UPDATE;
      ST_UPDATE: if (!(out_valid && !out_ready && last)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Output decode. The start strobes are registered, so each product starts in
  // the cycle after its strobe is decoded, once the step and the operand registers have settled.
  always_comb begin
    m_start_next = 1'b0;
    r_start_next = 1'b0;
    unique case (state)
      ST_IDLE:  m_start_next = in_valid;
      ST_MUL:   m_start_next = m_done && step != 4'd5;
      ST_CLASS: m_start_next = (state_next == ST_SQ);
      ST_DIV:   m_start_next = (dcnt == 5'd0);
      ST_SCALE: m_start_next = m_done;
      ST_SQ: begin
        m_start_next = m_done && step != 4'd2;
        r_start_next = m_done && step == 4'd2;
      end
      default:  m_start_next = 1'b0;
    endcase
  end

  assign take = (cnt < CntW'(MaxSegments)) && (cnt == '0 || r_root < run_dist);
  assign emit = (state == ST_UPDATE) && (state_next == ST_IDLE) && last;

  logic [DistW-1:0] sc;
  assign sc = DistW'((m_prod + SqW'(1 << 23)) >> 24);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      m_start   <= 1'b0;
      r_start   <= 1'b0;
      run_dist  <= '1;
      run_idx   <= '0;
      run_near  <= 1'b0;
      cnt       <= '0;
    end else begin
      state   <= state_next;
      m_start <= m_start_next;
      r_start <= r_start_next;
      if (emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (state_next == ST_MUL) begin
          w[0] <= DiffW'(query_x) - DiffW'(end_a_x);
          w[1] <= DiffW'(query_y) - DiffW'(end_a_y);
          w[2] <= DiffW'(query_z) - DiffW'(end_a_z);
          d[0] <= DiffW'(end_b_x) - DiffW'(end_a_x);
          d[1] <= DiffW'(end_b_y) - DiffW'(end_a_y);
          d[2] <= DiffW'(end_b_z) - DiffW'(end_a_z);
          e[0] <= DiffW'(query_x) - DiffW'(end_b_x);
          e[1] <= DiffW'(query_y) - DiffW'(end_b_y);
          e[2] <= DiffW'(query_z) - DiffW'(end_b_z);
          last <= last_segment;
          step <= '0;
          len2 <= '0;
          dot  <= '0;
        end
        ST_MUL: if (m_done) begin
          if (step < 4'd3) len2 <= len2 + m_signed;
          else             dot  <= dot + m_signed;
          step <= step + 4'd1;
        end
        ST_CLASS: begin
          step  <= '0;
          sumsq <= '0;
          rem   <= dot;
          tq    <= '0;
          dcnt  <= 5'd25;
          if (len2 == '0 || dot[AccW-1]) begin
            sel <= 2'd0; near <= 1'b1;
          end else if (dot > len2) begin
            sel <= 2'd1; near <= 1'b0;
          end else begin
            sel <= 2'd2; near <= ({dot[AccW-2:0], 1'b0} < len2);
          end
        end
        ST_DIV: begin
          if (dcnt == 5'd25) begin
            if (!(rem < len2)) begin rem <= rem - len2; tq <= TW'(1); end
          end else if (dcnt != 5'd0) begin
            if (!dtrial[AccW]) begin
              rem <= dtrial[AccW-1:0]; tq <= {tq[TW-2:0], 1'b1};
            end else begin
              rem <= {rem[AccW-2:0], 1'b0}; tq <= {tq[TW-2:0], 1'b0};
            end
          end
          if (dcnt != 5'd0) dcnt <= dcnt - 5'd1;
        end
        ST_SCALE: if (m_done) begin
          v[step[1:0]] <= w[step[1:0]] -
            (d[step[1:0]][DiffW-1] ? -DiffW'(sc) : DiffW'(sc));
          step <= (step == 4'd2) ? '0 : step + 4'd1;
        end
        ST_SQ: if (m_done) begin
          sumsq <= sumsq + AccW'(m_prod);
          step  <= step + 4'd1;
        end
        ST_UPDATE: if (state_next == ST_IDLE) begin
          if (last) begin
            // The closing item competes too, then the search starts over.
            best_index       <= take ? IdxW'(cnt) : run_idx;
            best_distance    <= take ? r_root : run_dist;
            nearer_first_end <= take ? near : run_near;
            count_overflow   <= (cnt >= CntW'(MaxSegments));
            run_dist <= '1;
            run_idx  <= '0;
            run_near <= 1'b0;
            cnt      <= '0;
          end else begin
            if (take) begin
              run_dist <= r_root;
              run_idx  <= IdxW'(cnt);
              run_near <= near;
            end
            if (cnt <= CntW'(MaxSegments)) cnt <= cnt + CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/nss_checker.sv
// Port-level checks for the nearest segment search, bound to the top level.
module nss_checker import nss_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DistW-1:0] best_distance,
  input logic [IdxW-1:0]  best_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_distance) && $stable(best_index))
    else $error("result changed while stalled");

  a_no_accept_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two items in a row");

  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_segment_search nss_checker u_nss_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .best_distance(best_distance), .best_index(best_index)
);
